### rtl/core/mscs_pkg.sv
// Package for the mail session command sequencer.
// Holds the command, phase and reply codes and the decision result type.
// No dependencies.
package mscs_pkg;

	typedef enum logic [3:0] {
		OP_HELO    = 4'd0,
		OP_EHLO    = 4'd1,
		OP_VRFY    = 4'd2,
		OP_MAIL    = 4'd3,
		OP_RCPT    = 4'd4,
		OP_DATA    = 4'd5,
		OP_RSET    = 4'd6,
		OP_QUIT    = 4'd7,
		OP_UNKNOWN = 4'd8
	} op_t;

	typedef enum logic [2:0] {
		PH_BEGIN = 3'd0,
		PH_WAIT  = 3'd1,
		PH_ENV   = 3'd2,
		PH_RCPT  = 3'd3,
		PH_WRITE = 3'd4,
		PH_READY = 3'd5
	} phase_t;

	typedef enum logic [3:0] {
		RP_NONE         = 4'd0,
		RP_GREET        = 4'd1,
		RP_EHLO_LIST    = 4'd2,
		RP_NEED_HELO    = 4'd3,
		RP_NEED_MAIL    = 4'd4,
		RP_NEED_RCPT    = 4'd5,
		RP_UNKNOWN      = 4'd6,
		RP_BYE          = 4'd7,
		RP_NEED_MAIL_VF = 4'd8,
		RP_OK           = 4'd9,
		RP_NO_USER      = 4'd10,
		RP_VRFY_FOUND   = 4'd11,
		RP_NEED_RCPT_VF = 4'd12,
		RP_START_INPUT  = 4'd13
	} reply_t;

	typedef struct packed {
		reply_t     reply_kind;
		phase_t     next_phase;
		logic       close_session;
		logic       save_sender;
		logic       save_main_recipient;
		logic       save_copy;
		logic [2:0] copy_slot;
		logic       append_body;
		logic       clear_message;
	} result_t;

endpackage

### rtl/core/mscs_in_stage.sv
// Input register stage of the mail session command sequencer.
// Captures one request per cycle while in_ready is high; depends on nothing outside this file.
module mscs_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [3:0] op,
	input  logic       line_is_end,
	input  logic       lookup_hit,
	input  logic       advance,
	output logic       valid_s1,
	output logic [3:0] op_s1,
	output logic       end_s1,
	output logic       hit_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1  <= op;
			end_s1 <= line_is_end;
			hit_s1 <= lookup_hit;
		end
	end

endmodule

### rtl/core/mscs_decide.sv
// Session decision logic and state of the mail session command sequencer.
// Uses mscs_pkg for codes and the result type.
module mscs_decide #(
	parameter int MAX_COPIES = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [3:0]       op_s1,
	input  logic             end_s1,
	input  logic             hit_s1,
	output mscs_pkg::result_t result
);
	import mscs_pkg::*;

	localparam int CW = $clog2(MAX_COPIES + 1);

	phase_t        phase_q;
	logic [CW-1:0] copy_count_q;
	logic [CW-1:0] count_next;
	logic [CW+2:0] count_ext;
	phase_t        ph;
	logic          slots_free;

	assign count_ext  = {3'b000, copy_count_q};
	assign slots_free = copy_count_q < CW'(MAX_COPIES);

	always_comb begin
		case (phase_q)
			PH_BEGIN, PH_WAIT, PH_ENV, PH_RCPT, PH_WRITE, PH_READY: ph = phase_q;
			default: ph = PH_BEGIN;
		endcase
	end

	always_comb begin
		result = '0;
		result.reply_kind = RP_NONE;
		result.next_phase = ph;
		count_next = copy_count_q;
		if (ph == PH_WRITE) begin
			if (end_s1) begin
				result.reply_kind = RP_OK;
				result.next_phase = PH_READY;
			end else begin
				result.append_body = 1'b1;
			end
		end else if (op_s1 == OP_QUIT) begin
			result.reply_kind    = RP_BYE;
			result.close_session = 1'b1;
			result.next_phase    = PH_BEGIN;
			count_next           = '0;
		end else if (op_s1 > OP_QUIT) begin
			result.reply_kind = RP_UNKNOWN;
		end else if (ph == PH_BEGIN) begin
			case (op_s1)
				OP_HELO: begin
					result.reply_kind = RP_GREET;
					result.next_phase = PH_WAIT;
				end
				OP_EHLO: begin
					result.reply_kind = RP_EHLO_LIST;
					result.next_phase = PH_WAIT;
				end
				OP_RCPT: result.reply_kind = RP_NEED_MAIL;
				OP_DATA: result.reply_kind = RP_NEED_RCPT;
				default: result.reply_kind = RP_NEED_HELO;
			endcase
		end else if (op_s1 == OP_VRFY) begin
			result.reply_kind = hit_s1 ? RP_VRFY_FOUND : RP_NO_USER;
		end else if (ph == PH_WAIT || ph == PH_READY) begin
			case (op_s1)
				OP_HELO, OP_EHLO: result.reply_kind = RP_NEED_MAIL_VF;
				OP_MAIL: begin
					result.reply_kind  = RP_OK;
					result.next_phase  = PH_ENV;
					result.save_sender = 1'b1;
					if (ph == PH_READY) begin
						result.clear_message = 1'b1;
						count_next           = '0;
					end
				end
				OP_RCPT: result.reply_kind = RP_NEED_MAIL;
				OP_DATA: result.reply_kind = RP_NEED_RCPT;
				default: result.reply_kind = (ph == PH_WAIT) ? RP_OK : RP_NEED_MAIL;
			endcase
		end else begin
			case (op_s1)
				OP_HELO, OP_EHLO: result.reply_kind = RP_NEED_RCPT_VF;
				OP_MAIL: result.reply_kind = (ph == PH_ENV) ? RP_NEED_RCPT_VF : RP_NEED_RCPT;
				OP_RCPT: begin
					if (!hit_s1) begin
						result.reply_kind = RP_NO_USER;
					end else begin
						result.reply_kind = RP_OK;
						if (ph == PH_ENV) begin
							result.save_main_recipient = 1'b1;
							result.next_phase          = PH_RCPT;
						end else if (slots_free) begin
							result.save_copy = 1'b1;
							result.copy_slot = count_ext[2:0];
							count_next       = copy_count_q + CW'(1);
						end
					end
				end
				OP_DATA: begin
					if (ph == PH_RCPT) begin
						result.reply_kind = RP_START_INPUT;
						result.next_phase = PH_WRITE;
					end else begin
						result.reply_kind = RP_NEED_RCPT;
					end
				end
				default: begin
					result.reply_kind = RP_OK;
					result.next_phase = PH_WAIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_BEGIN;
			copy_count_q <= '0;
		end else if (advance) begin
			phase_q      <= result.next_phase;
			copy_count_q <= count_next;
		end
	end

endmodule

### rtl/core/mail_session_command_sequencer_core.sv
// Top level of the mail session command sequencer.
// Uses mscs_pkg, mscs_in_stage and mscs_decide.
//
//   channel | valid    | ready     | payload
//   input   | in_valid | in_ready  | op, line_is_end, lookup_hit
//   output  | out_valid| out_ready | reply_kind .. clear_message
//
// A request accepted into the input register moves into the result register
// once the output is free, and its result is then offered; a new request is
// taken every cycle while the output does not stall. The session phase and
// copy count update as a request moves into the result register. Reset clears
// both stages and returns the phase to begin. A stalled output holds its
// result while the input register absorbs one more.
module mail_session_command_sequencer_core #(
	parameter int MAX_COPIES = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [3:0] op,
	input  logic       line_is_end,
	input  logic       lookup_hit,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] reply_kind,
	output logic [2:0] next_phase,
	output logic       close_session,
	output logic       save_sender,
	output logic       save_main_recipient,
	output logic       save_copy,
	output logic [2:0] copy_slot,
	output logic       append_body,
	output logic       clear_message
);
	import mscs_pkg::*;

	logic       valid_s1;
	logic [3:0] op_s1;
	logic       end_s1;
	logic       hit_s1;
	logic       advance;
	logic       valid_s2;
	result_t    result;
	result_t    result_s2;

	assign advance = valid_s1 && (!valid_s2 || out_ready);

	mscs_in_stage u_in_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.line_is_end (line_is_end),
		.lookup_hit  (lookup_hit),
		.advance     (advance),
		.valid_s1    (valid_s1),
		.op_s1       (op_s1),
		.end_s1      (end_s1),
		.hit_s1      (hit_s1)
	);

	mscs_decide #(
		.MAX_COPIES (MAX_COPIES)
	) u_decide (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.op_s1   (op_s1),
		.end_s1  (end_s1),
		.hit_s1  (hit_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid           = valid_s2;
	assign reply_kind          = result_s2.reply_kind;
	assign next_phase          = result_s2.next_phase;
	assign close_session       = result_s2.close_session;
	assign save_sender         = result_s2.save_sender;
	assign save_main_recipient = result_s2.save_main_recipient;
	assign save_copy           = result_s2.save_copy;
	assign copy_slot           = result_s2.copy_slot;
	assign append_body         = result_s2.append_body;
	assign clear_message       = result_s2.clear_message;

endmodule

### tb/mscs_session_checker.sv
`timescale 1ns / 100ps
// Checker for the mail session command sequencer: watches both channels,
// predicts each reply from its own copy of the session state and compares.
// Depends on mscs_pkg for the command, phase and reply codes.
module mscs_session_checker #(
	parameter int MAX_COPIES = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [3:0] op,
	input  logic       line_is_end,
	input  logic       lookup_hit,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [3:0] reply_kind,
	input  logic [2:0] next_phase,
	input  logic       close_session,
	input  logic       save_sender,
	input  logic       save_main_recipient,
	input  logic       save_copy,
	input  logic [2:0] copy_slot,
	input  logic       append_body,
	input  logic       clear_message,
	output int         errors,
	output int         outstanding
);
	import mscs_pkg::*;

	phase_t     session_phase;
	logic [3:0] copy_count;
	result_t    expected_replies[$];
	int         fail_count = 0;

	function automatic result_t decide_command(logic [3:0] cmd, logic last_line, logic found);
		result_t r;
		phase_t  ph;
		r = '0;
		ph = (session_phase > PH_READY) ? PH_BEGIN : session_phase;
		r.next_phase = ph;
		if (ph == PH_WRITE) begin
			if (last_line) begin
				r.reply_kind = RP_OK;
				r.next_phase = PH_READY;
			end else begin
				r.append_body = 1'b1;
			end
		end else if (cmd == OP_QUIT) begin
			r.reply_kind = RP_BYE;
			r.close_session = 1'b1;
			r.next_phase = PH_BEGIN;
			copy_count = '0;
		end else if (cmd > OP_QUIT) begin
			r.reply_kind = RP_UNKNOWN;
		end else if (ph == PH_BEGIN) begin
			case (cmd)
				OP_HELO: begin
					r.reply_kind = RP_GREET;
					r.next_phase = PH_WAIT;
				end
				OP_EHLO: begin
					r.reply_kind = RP_EHLO_LIST;
					r.next_phase = PH_WAIT;
				end
				OP_RCPT: r.reply_kind = RP_NEED_MAIL;
				OP_DATA: r.reply_kind = RP_NEED_RCPT;
				default: r.reply_kind = RP_NEED_HELO;
			endcase
		end else if (cmd == OP_VRFY) begin
			r.reply_kind = found ? RP_VRFY_FOUND : RP_NO_USER;
		end else if (ph == PH_WAIT || ph == PH_READY) begin
			case (cmd)
				OP_HELO, OP_EHLO: r.reply_kind = RP_NEED_MAIL_VF;
				OP_MAIL: begin
					r.reply_kind = RP_OK;
					r.next_phase = PH_ENV;
					r.save_sender = 1'b1;
					if (ph == PH_READY) begin
						r.clear_message = 1'b1;
						copy_count = '0;
					end
				end
				OP_RCPT: r.reply_kind = RP_NEED_MAIL;
				OP_DATA: r.reply_kind = RP_NEED_RCPT;
				default: r.reply_kind = (ph == PH_WAIT) ? RP_OK : RP_NEED_MAIL;
			endcase
		end else begin
			case (cmd)
				OP_HELO, OP_EHLO: r.reply_kind = RP_NEED_RCPT_VF;
				OP_MAIL: r.reply_kind = (ph == PH_ENV) ? RP_NEED_RCPT_VF : RP_NEED_RCPT;
				OP_RCPT: begin
					if (!found) begin
						r.reply_kind = RP_NO_USER;
					end else begin
						r.reply_kind = RP_OK;
						if (ph == PH_ENV) begin
							r.save_main_recipient = 1'b1;
							r.next_phase = PH_RCPT;
						end else if (copy_count < MAX_COPIES) begin
							r.save_copy = 1'b1;
							r.copy_slot = copy_count[2:0];
							copy_count = copy_count + 4'd1;
						end
					end
				end
				OP_DATA: begin
					if (ph == PH_RCPT) begin
						r.reply_kind = RP_START_INPUT;
						r.next_phase = PH_WRITE;
					end else begin
						r.reply_kind = RP_NEED_RCPT;
					end
				end
				default: begin
					r.reply_kind = RP_OK;
					r.next_phase = PH_WAIT;
				end
			endcase
		end
		session_phase = r.next_phase;
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count = fail_count + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			session_phase = PH_BEGIN;
			copy_count = '0;
			expected_replies.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_replies.size() == 0) begin
					$error("reply with no request waiting: reply_kind %0d", reply_kind);
					fail_count = fail_count + 1;
				end else begin
					want = expected_replies.pop_front();
					check_field("reply_kind", int'(want.reply_kind), int'(reply_kind));
					check_field("next_phase", int'(want.next_phase), int'(next_phase));
					check_field("close_session", int'(want.close_session),
						int'(close_session));
					check_field("save_sender", int'(want.save_sender), int'(save_sender));
					check_field("save_main_recipient", int'(want.save_main_recipient),
						int'(save_main_recipient));
					check_field("save_copy", int'(want.save_copy), int'(save_copy));
					check_field("copy_slot", int'(want.copy_slot), int'(copy_slot));
					check_field("append_body", int'(want.append_body), int'(append_body));
					check_field("clear_message", int'(want.clear_message),
						int'(clear_message));
				end
			end
			if (in_valid && in_ready)
				expected_replies.push_back(decide_command(op, line_is_end, lookup_hit));
		end
		outstanding <= expected_replies.size();
		errors <= fail_count;
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Top of the testbench for mail_session_command_sequencer_core: drives mail
// sessions and noise, stalls the reply side and gives the verdict.
// Depends on mscs_pkg, the core and mscs_session_checker.
module testbench;
	import mscs_pkg::*;

	localparam int         COPY_SLOTS     = 8;
	localparam int         REQUEST_TARGET = 600;
	localparam int         WATCHDOG_LIMIT = 1000;
	localparam logic [3:0] OP_LAST_CODE   = 4'hF;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [3:0] op = '0;
	logic       line_is_end = 1'b0;
	logic       lookup_hit = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [3:0] reply_kind;
	logic [2:0] next_phase;
	logic       close_session;
	logic       save_sender;
	logic       save_main_recipient;
	logic       save_copy;
	logic [2:0] copy_slot;
	logic       append_body;
	logic       clear_message;
	int         errors;
	int         outstanding;

	int         burst_left = 0;
	int         sent_count = 0;
	int         idle_cycles = 0;
	int         stall_left = 0;
	logic [9:0] rx_cycle = '0;

	always #1 clk = ~clk;

	mail_session_command_sequencer_core #(.MAX_COPIES(COPY_SLOTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .line_is_end(line_is_end), .lookup_hit(lookup_hit),
		.out_valid(out_valid), .out_ready(out_ready),
		.reply_kind(reply_kind), .next_phase(next_phase),
		.close_session(close_session), .save_sender(save_sender),
		.save_main_recipient(save_main_recipient), .save_copy(save_copy),
		.copy_slot(copy_slot), .append_body(append_body),
		.clear_message(clear_message)
	);

	mscs_session_checker #(.MAX_COPIES(COPY_SLOTS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .line_is_end(line_is_end), .lookup_hit(lookup_hit),
		.out_valid(out_valid), .out_ready(out_ready),
		.reply_kind(reply_kind), .next_phase(next_phase),
		.close_session(close_session), .save_sender(save_sender),
		.save_main_recipient(save_main_recipient), .save_copy(save_copy),
		.copy_slot(copy_slot), .append_body(append_body),
		.clear_message(clear_message),
		.errors(errors), .outstanding(outstanding)
	);

	// The reply side cycles through always ready, light and heavy random
	// stalls, and runs of back-to-back stalls.
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 10'd1;
		case (rx_cycle[9:8])
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= ($urandom_range(0, 3) != 0);
			2'd2: out_ready <= $urandom_range(0, 1);
			default: begin
				if (stall_left != 0) begin
					stall_left <= stall_left - 1;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
					if ($urandom_range(0, 3) == 0)
						stall_left <= $urandom_range(1, 8);
				end
			end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic send_request(input logic [3:0] cmd, input logic last_line, input logic found);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		op <= cmd;
		line_is_end <= last_line;
		lookup_hit <= found;
		do @(posedge clk); while (!in_ready);
		burst_left = burst_left - 1;
		sent_count = sent_count + 1;
	endtask

	task automatic send_noise();
		send_request(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endtask

	// A command that is occasionally preceded by a stray request.
	task automatic send_command(input logic [3:0] cmd, input logic found);
		if ($urandom_range(0, 11) == 0)
			send_noise();
		send_request(cmd, 1'($urandom_range(0, 1)), found);
	endtask

	task automatic wait_for_replies();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic run_session();
		int n;
		send_command($urandom_range(0, 1) ? OP_HELO : OP_EHLO, 1'($urandom_range(0, 1)));
		repeat ($urandom_range(0, 2)) send_command(OP_VRFY, 1'($urandom_range(0, 1)));
		repeat ($urandom_range(1, 3)) begin
			send_command(OP_MAIL, 1'($urandom_range(0, 1)));
			repeat ($urandom_range(0, 1)) send_command(OP_RCPT, 1'b0);
			send_command(OP_RCPT, 1'b1);
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(COPY_SLOTS, COPY_SLOTS + 2)
				: $urandom_range(0, 3);
			repeat (n) send_command(OP_RCPT, ($urandom_range(0, 5) != 0));
			send_command(OP_DATA, 1'($urandom_range(0, 1)));
			repeat ($urandom_range(0, 4))
				send_request(4'($urandom_range(0, 15)), 1'b0, 1'($urandom_range(0, 1)));
			send_request(4'($urandom_range(0, 15)), 1'b1, 1'($urandom_range(0, 1)));
		end
		case ($urandom_range(0, 3))
			0: begin
				send_command(OP_RSET, 1'($urandom_range(0, 1)));
				send_command(OP_QUIT, 1'($urandom_range(0, 1)));
			end
			3: ;
			default: send_command(OP_QUIT, 1'($urandom_range(0, 1)));
		endcase
	endtask

	initial begin : stimulus
		int round;
		round = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(OP_UNKNOWN, 1'b0, 1'b0);
		send_request(OP_LAST_CODE, 1'b1, 1'b1);
		send_request(OP_VRFY, 1'b0, 1'b1);
		send_request(OP_MAIL, 1'b1, 1'b0);
		send_request(OP_RCPT, 1'b0, 1'b1);
		send_request(OP_DATA, 1'b0, 1'b0);
		send_request(OP_RSET, 1'b0, 1'b0);
		send_request(OP_EHLO, 1'b0, 1'b0);
		send_request(OP_VRFY, 1'b0, 1'b1);
		send_request(OP_VRFY, 1'b1, 1'b0);
		send_request(OP_HELO, 1'b0, 1'b0);
		send_request(OP_RCPT, 1'b0, 1'b1);
		send_request(OP_DATA, 1'b0, 1'b0);
		send_request(OP_RSET, 1'b0, 1'b0);
		send_request(OP_MAIL, 1'b0, 1'b0);
		send_request(OP_EHLO, 1'b0, 1'b0);
		send_request(OP_MAIL, 1'b0, 1'b0);
		send_request(OP_DATA, 1'b0, 1'b0);
		send_request(OP_RCPT, 1'b0, 1'b0);
		send_request(OP_RCPT, 1'b0, 1'b1);
		send_request(OP_RCPT, 1'b0, 1'b1);
		send_request(OP_MAIL, 1'b0, 1'b0);
		send_request(OP_DATA, 1'b0, 1'b0);
		send_request(OP_QUIT, 1'b0, 1'b1);
		send_request(OP_LAST_CODE, 1'b1, 1'b0);
		send_request(OP_RSET, 1'b0, 1'b0);
		send_request(OP_MAIL, 1'b0, 1'b0);
		send_request(OP_RSET, 1'b0, 1'b0);
		send_request(OP_QUIT, 1'b1, 1'b0);
		wait_for_replies();

		while (sent_count < REQUEST_TARGET) begin
			round = round + 1;
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 6)) send_noise();
			else
				run_session();
			if (round % 10 == 0)
				wait_for_replies();
		end

		wait_for_replies();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
